### sv/aipu_pkg.sv
// Shared types and constants for the pixel format converter.
`timescale 1ns / 1ps
package aipu_pkg;

  localparam int FMT_W  = 4;
  localparam int SPAN_W = 9;

  localparam logic [FMT_W-1:0] FMT_IDX1     = 4'd0;
  localparam logic [FMT_W-1:0] FMT_IDX2     = 4'd1;
  localparam logic [FMT_W-1:0] FMT_IDX4     = 4'd2;
  localparam logic [FMT_W-1:0] FMT_IDX8     = 4'd3;
  localparam logic [FMT_W-1:0] FMT_ARGB4444 = 4'd4;
  localparam logic [FMT_W-1:0] FMT_X555     = 4'd5;
  localparam logic [FMT_W-1:0] FMT_1555     = 4'd6;
  localparam logic [FMT_W-1:0] FMT_565      = 4'd7;
  localparam logic [FMT_W-1:0] FMT_RGB888   = 4'd8;
  localparam logic [FMT_W-1:0] FMT_ARGB8888 = 4'd9;
  localparam logic [FMT_W-1:0] FMT_RESET    = FMT_ARGB8888;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SEARCH,
    OP_PACK
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic              reverse;
    logic [SPAN_W-1:0] span;
    logic [FMT_W-1:0]  format;
    logic [7:0]        entry_index;
    logic [23:0]       entry_color;
    logic [31:0]       pixel_color;
  } job_t;

endpackage

### sv/aipu_front.sv
// Front end: takes items, holds the format register and classifies each item into a job.
`timescale 1ns / 1ps
module aipu_front #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode,
  input  logic [7:0]               entry_index,
  input  logic [23:0]              entry_color,
  input  logic [31:0]              pixel_color,
  input  logic                     cfg_we,
  input  logic [aipu_pkg::FMT_W-1:0] cfg_data,
  input  logic                     q_full,
  output logic                     push,
  output aipu_pkg::job_t           job
);
  import aipu_pkg::*;

  localparam logic [SPAN_W-1:0] DEPTH_SPAN = SPAN_W'(PALETTE_DEPTH);

  logic [FMT_W-1:0]  target_format;
  logic              held_valid;
  job_t              held;
  job_t              job_next;
  logic              keep;
  logic              accept;
  logic [SPAN_W-1:0] span_raw;

  assign busy   = held_valid & q_full;
  assign accept = start & ~busy;
  assign push   = held_valid & ~q_full;
  assign job    = held;

  always_comb begin
    span_raw = SPAN_W'(2);
    job_next = '0;
    keep     = 1'b1;
    job_next.format      = target_format;
    job_next.entry_index = entry_index;
    job_next.entry_color = entry_color;
    job_next.pixel_color = pixel_color;
    unique case (target_format) inside
      FMT_IDX1: span_raw = SPAN_W'(2);
      FMT_IDX2: span_raw = SPAN_W'(4);
      FMT_IDX4: span_raw = SPAN_W'(16);
      FMT_IDX8: span_raw = SPAN_W'(256);
      default:  span_raw = SPAN_W'(2);
    endcase
    job_next.span    = (span_raw > DEPTH_SPAN) ? DEPTH_SPAN : span_raw;
    job_next.reverse = (target_format == FMT_IDX1);
    if (!mode) begin
      job_next.op = OP_WRITE;
      keep        = ({1'b0, entry_index} < DEPTH_SPAN);
    end else if (target_format == FMT_IDX1 || target_format == FMT_IDX2 ||
                 target_format == FMT_IDX4 || target_format == FMT_IDX8) begin
      job_next.op = OP_SEARCH;
    end else begin
      job_next.op = OP_PACK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_format <= FMT_RESET;
    end else if (cfg_we) begin
      target_format <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= keep;
    end else if (!q_full) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= job_next;
    end
  end

endmodule

### sv/aipu_queue.sv
// Two-entry job queue between front and back ends.
`timescale 1ns / 1ps
module aipu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aipu_pkg::job_t push_job,
  input  logic           pop,
  output aipu_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);
  import aipu_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/aipu_back.sv
// Back end: palette store, sequential palette search, 16-bit packing and 32-bit pass-through.
`timescale 1ns / 1ps
module aipu_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  aipu_pkg::job_t q_job,
  output logic           pop,
  output logic           done,
  output logic [7:0]     palette_index,
  output logic [31:0]    color_word,
  output logic [7:0]     alpha_level
);
  import aipu_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  back_state_t        state;
  back_state_t        state_next;
  logic [23:0]        mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] valid;
  logic [23:0]        rdata;
  logic               rvalid;
  logic [SPAN_W-1:0]  fetch;
  logic [SPAN_W-1:0]  span;
  logic               reverse;
  logic               cmp_live;
  logic [AW-1:0]      cmp_addr;
  logic [31:0]        pixel;
  logic [SPAN_W-1:0]  raddr_full;
  logic [AW-1:0]      raddr;
  logic [23:0]        entry;
  logic               match;
  logic               wr_en;
  logic               pack_now;
  logic               start_search;
  logic               issue;
  logic               hit;
  logic               miss;
  logic [39:0]        packed_res;

  function automatic logic [39:0] pack_pixel(input logic [FMT_W-1:0] fmt,
                                             input logic [31:0] pix);
    logic [7:0]  a;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [31:0] word;
    logic [7:0]  alv;
    a = pix[31:24];
    r = pix[23:16];
    g = pix[15:8];
    b = pix[7:0];
    word = '0;
    alv  = '0;
    case (fmt)
      FMT_ARGB4444: begin
        word = {16'd0, a[7:4], r[7:4], g[7:4], b[7:4]};
        alv  = {4'd0, a[7:4]};
      end
      FMT_X555: begin
        word = {16'd0, 1'b0, r[7:3], g[7:3], b[7:3]};
        alv  = {3'd0, a[7:3]};
      end
      FMT_1555: begin
        word = {16'd0, a[7], r[7:3], g[7:3], b[7:3]};
        alv  = {3'd0, a[7:3]};
      end
      FMT_565: begin
        word = {16'd0, r[7:3], g[7:2], b[7:3]};
        alv  = {2'd0, a[7:2]};
      end
      FMT_RGB888, FMT_ARGB8888: begin
        word = pix;
      end
      default: begin
        word = '0;
      end
    endcase
    return {word, alv};
  endfunction

  assign raddr_full = reverse ? (span - SPAN_W'(1) - fetch) : fetch;
  assign raddr      = raddr_full[AW-1:0];
  assign entry      = rvalid ? rdata : 24'd0;
  assign match      = cmp_live & (entry == pixel[23:0]);
  assign packed_res = pack_pixel(q_job.format, q_job.pixel_color);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start_search) state_next = S_SEARCH;
      S_SEARCH: if (hit || miss) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    wr_en        = 1'b0;
    pack_now     = 1'b0;
    start_search = 1'b0;
    issue        = 1'b0;
    hit          = 1'b0;
    miss         = 1'b0;
    unique case (state)
      S_IDLE: begin
        pop          = ~q_empty;
        wr_en        = pop & (q_job.op == OP_WRITE);
        pack_now     = pop & (q_job.op == OP_PACK);
        start_search = pop & (q_job.op == OP_SEARCH);
      end
      S_SEARCH: begin
        hit   = match;
        miss  = ~match & (fetch == span);
        issue = ~match & (fetch != span);
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_job.entry_index[AW-1:0]] <= q_job.entry_color;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[q_job.entry_index[AW-1:0]] <= 1'b1;
      end
      rvalid <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live <= 1'b0;
    end else if (start_search) begin
      cmp_live <= 1'b0;
    end else if (issue) begin
      cmp_live <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_search) begin
      fetch   <= '0;
      span    <= q_job.span;
      reverse <= q_job.reverse;
      pixel   <= q_job.pixel_color;
    end else if (issue) begin
      fetch    <= fetch + SPAN_W'(1);
      cmp_addr <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pack_now | hit | miss;
    end
  end

  always_ff @(posedge clk) begin
    if (pack_now) begin
      palette_index <= 8'd0;
      color_word    <= packed_res[39:8];
      alpha_level   <= packed_res[7:0];
    end else if (hit) begin
      palette_index <= 8'(cmp_addr);
      color_word    <= 32'd0;
      alpha_level   <= pixel[31:24];
    end else if (miss) begin
      palette_index <= 8'd0;
      color_word    <= 32'd0;
      alpha_level   <= 8'd0;
    end
  end

endmodule

### sv/argb_to_indexed_or_packed_pixel_unit.sv
// Top level of the ARGB8888 pixel format converter with palette match.
`timescale 1ns / 1ps
// A pixel for a packed or pass-through format, or a palette write, is taken
// as it is popped, so such items stream at one per cycle while no palette
// search holds the back end; done for a pixel result is registered, after
// the front stage and a queue slot. A pixel for an indexed format walks the
// palette one entry per cycle through the single read port of the palette
// memory, so it holds the back end until the first match or the last of its
// span entries (span is 2, 4, 16 or 256 entries, cut to PALETTE_DEPTH). A
// two-entry queue lets the front keep taking items meanwhile; busy rises
// when that queue and the front stage are both full. Results appear on done
// for exactly one cycle and cannot be held off. The palette is empty (all
// zero) straight after reset; no clearing pass is needed.
module argb_to_indexed_or_packed_pixel_unit #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic [7:0]                 entry_index,
  input  logic [23:0]                entry_color,
  input  logic [31:0]                pixel_color,
  input  logic                       cfg_we,
  input  logic [aipu_pkg::FMT_W-1:0] cfg_data,
  output logic                       done,
  output logic [7:0]                 palette_index,
  output logic [31:0]                color_word,
  output logic [7:0]                 alpha_level
);
  import aipu_pkg::*;

  job_t front_job;
  job_t q_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  aipu_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .entry_index (entry_index),
    .entry_color (entry_color),
    .pixel_color (pixel_color),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (push),
    .job         (front_job)
  );

  aipu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .pop_job  (q_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  aipu_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_job         (q_job),
    .pop           (pop),
    .done          (done),
    .palette_index (palette_index),
    .color_word    (color_word),
    .alpha_level   (alpha_level)
  );

endmodule

### sv/aipu_checker.sv
// Port-level checks for the pixel format converter, bound to the top level.
`timescale 1ns / 1ps
module aipu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       mode,
  input logic [7:0]                 entry_index,
  input logic [23:0]                entry_color,
  input logic [31:0]                pixel_color,
  input logic                       cfg_we,
  input logic [aipu_pkg::FMT_W-1:0] cfg_data,
  input logic                       done,
  input logic [7:0]                 palette_index,
  input logic [31:0]                color_word,
  input logic [7:0]                 alpha_level
);

  a_rst_done: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_rst_busy: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

  a_index_word: assert property (@(posedge clk) disable iff (rst)
    done && palette_index != 8'd0 |-> color_word == 32'd0)
    else $error("palette hit carries a colour word");

  a_wide_alpha: assert property (@(posedge clk) disable iff (rst)
    done && color_word[31:16] != 16'd0 |-> alpha_level == 8'd0 && palette_index == 8'd0)
    else $error("pass-through result carries alpha or index");

endmodule

bind argb_to_indexed_or_packed_pixel_unit aipu_checker u_aipu_checker (.*);
